[sv/rsrp_pkg.sv]
// Package for the rectangle sum block: field widths, configuration register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rsrp_pkg;

  // Field widths
  localparam int ELEM_W     = 32;
  localparam int COORD_W    = 6;
  localparam int CNT_W      = 7;
  localparam int PREFIX_W   = 38;
  localparam int SUM_W      = 44;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd64;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_en;   // store the accepted element
    logic q_start;   // latch an accepted query
    logic issue;     // read the prefix pair of the current row
    logic acc_en;    // add the read pair into the accumulator
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_err;     // query on the input lines is out of range or inverted
    logic last_row;  // current row is the bottom row
    logic out_busy;  // output register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

[sv/rsrp_ifs.sv]
// Request and result channel interfaces of the rectangle sum block.
// Depends on rsrp_pkg for field widths.
`default_nettype none

interface rsrp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [rsrp_pkg::ELEM_W-1:0]  element;
  logic        [rsrp_pkg::COORD_W-1:0] top_row;
  logic        [rsrp_pkg::COORD_W-1:0] left_col;
  logic        [rsrp_pkg::COORD_W-1:0] bottom_row;
  logic        [rsrp_pkg::COORD_W-1:0] right_col;

  modport source (output valid, req_type, element, top_row, left_col, bottom_row,
                  right_col, input ready);
  modport sink   (input valid, req_type, element, top_row, left_col, bottom_row,
                  right_col, output ready);
endinterface

interface rsrp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsrp_pkg::SUM_W-1:0]  rect_sum;
  logic                               range_error;

  modport source (output valid, rect_sum, range_error, input ready);
  modport sink   (input valid, rect_sum, range_error, output ready);
endinterface

`default_nettype wire

[sv/rsrp_ctrl.sv]
// Controller of the rectangle sum block: accepts requests and sequences the
// row walk of a query. Depends on rsrp_pkg for cmd_t and sts_t.
`default_nettype none

module rsrp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_req_type,
  output      logic            in_ready,
  input  wire rsrp_pkg::sts_t  sts,
  output      rsrp_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   acc_en_r;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.acc_en   = acc_en_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == rsrp_pkg::REQ_LOAD) begin
            cmd.load_en = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            state_nxt   = sts.q_err ? ST_FINISH : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_row) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last row's pair is added this cycle
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and accumulate strobe, registered from issue to line up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= cmd.issue;
    end
  end

endmodule

`default_nettype wire

[sv/rsrp_dp.sv]
// Datapath of the rectangle sum block: configuration registers, load
// position, prefix store, row accumulator and output register.
// Depends on rsrp_pkg.
`default_nettype none

module rsrp_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [rsrp_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [rsrp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic signed [rsrp_pkg::ELEM_W-1:0]   element,
  input  wire logic [rsrp_pkg::COORD_W-1:0]         top_row,
  input  wire logic [rsrp_pkg::COORD_W-1:0]         left_col,
  input  wire logic [rsrp_pkg::COORD_W-1:0]         bottom_row,
  input  wire logic [rsrp_pkg::COORD_W-1:0]         right_col,
  input  wire rsrp_pkg::cmd_t                       cmd,
  output      rsrp_pkg::sts_t                       sts,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [rsrp_pkg::SUM_W-1:0]    rect_sum,
  output      logic                                 range_error
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int CCW    = $clog2(MAX_COLS + 1);
  localparam int MW     = (RCW > CCW) ? RCW : CCW;
  localparam int CMP_W  = (MW > rsrp_pkg::CNT_W) ? MW : rsrp_pkg::CNT_W;
  localparam int PW     = rsrp_pkg::PREFIX_W;
  localparam int SW     = rsrp_pkg::SUM_W;
  localparam int EW     = rsrp_pkg::ELEM_W;

  localparam logic [CMP_W-1:0] ROWS_MAX = CMP_W'(MAX_ROWS);
  localparam logic [CMP_W-1:0] COLS_MAX = CMP_W'(MAX_COLS);
  localparam logic [CMP_W-1:0] ONE      = CMP_W'(1);
  localparam logic [AW-1:0]    ROW_PITCH = AW'(MAX_COLS);

  // Configuration registers
  logic [rsrp_pkg::CNT_W-1:0] row_count_r, col_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= rsrp_pkg::ROW_COUNT_RST;
      col_count_r <= rsrp_pkg::COL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        rsrp_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
        rsrp_pkg::REG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rows and columns in use: zero acts as one, clamp at the maximum
  logic [CMP_W-1:0] rows_c, cols_c, rcnt_ext, ccnt_ext;

  always_comb begin
    rcnt_ext = CMP_W'(row_count_r);
    ccnt_ext = CMP_W'(col_count_r);
    if (rcnt_ext == '0)          rows_c = ONE;
    else if (rcnt_ext > ROWS_MAX) rows_c = ROWS_MAX;
    else                          rows_c = rcnt_ext;
    if (ccnt_ext == '0)          cols_c = ONE;
    else if (ccnt_ext > COLS_MAX) cols_c = COLS_MAX;
    else                          cols_c = ccnt_ext;
  end

  // Load position and running row total
  logic [RW-1:0]          load_row_r;
  logic [CW-1:0]          load_col_r;
  logic signed [PW-1:0]   total_r;
  logic [RW-1:0]          load_row_nxt;
  logic [CW-1:0]          load_col_nxt;
  logic signed [PW-1:0]   total_nxt;
  logic signed [PW-1:0]   tot0, tot1;
  logic [CMP_W-1:0]       r1, c1, c2, r2;
  logic                   col_stale;
  logic [AW-1:0]          waddr;

  always_comb begin
    // wrap a position left stale by a register change
    col_stale = CMP_W'(load_col_r) >= cols_c;
    r1        = col_stale ? CMP_W'(load_row_r) + ONE : CMP_W'(load_row_r);
    if (r1 >= rows_c) r1 = '0;
    c1        = col_stale ? '0 : CMP_W'(load_col_r);
    tot0      = col_stale ? '0 : total_r;
    tot1      = tot0 + {{(PW-EW){element[EW-1]}}, element};
    waddr     = AW'(r1) * ROW_PITCH + AW'(c1);
    // advance past the written entry
    c2        = c1 + ONE;
    r2        = r1 + ONE;
    if (r2 >= rows_c) r2 = '0;
    if (c2 >= cols_c) begin
      load_col_nxt = '0;
      load_row_nxt = RW'(r2);
      total_nxt    = '0;
    end else begin
      load_col_nxt = CW'(c2);
      load_row_nxt = RW'(r1);
      total_nxt    = tot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      total_r    <= '0;
    end else if (cmd.load_en) begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      total_r    <= total_nxt;
    end
  end

  // Query checks on the input lines
  assign sts.q_err = (top_row > bottom_row) || (left_col > right_col) ||
                     (CMP_W'(bottom_row) >= rows_c) || (CMP_W'(right_col) >= cols_c);

  // Latched query
  logic [RW-1:0] row_r, bot_r;
  logic [CW-1:0] rcol_r, lcol_r;
  logic          lzero_r, err_r;

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      row_r   <= RW'(top_row);
      bot_r   <= RW'(bottom_row);
      rcol_r  <= CW'(right_col);
      lcol_r  <= (left_col == '0) ? CW'(right_col) : CW'(left_col - 1'b1);
      lzero_r <= (left_col == '0);
      err_r   <= sts.q_err;
    end else if (cmd.issue) begin
      row_r   <= row_r + 1'b1;
    end
  end

  assign sts.last_row = (row_r == bot_r);

  // Prefix store: one write port, two registered read ports
  logic signed [PW-1:0] mem [DEPTH];
  logic signed [PW-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]        raddr_a, raddr_b;

  assign raddr_a = AW'(row_r) * ROW_PITCH + AW'(rcol_r);
  assign raddr_b = AW'(row_r) * ROW_PITCH + AW'(lcol_r);

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[waddr] <= tot1;
    end
    if (cmd.issue) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  // Row accumulator
  logic signed [SW-1:0] acc_r;
  logic signed [SW-1:0] row_diff;

  always_comb begin
    row_diff = {{(SW-PW){rd_a_r[PW-1]}}, rd_a_r};
    if (!lzero_r) begin
      row_diff = row_diff - {{(SW-PW){rd_b_r[PW-1]}}, rd_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + row_diff;
    end
  end

  // Output register
  logic                 out_valid_r;
  logic signed [SW-1:0] out_sum_r;
  logic                 out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum_r <= err_r ? '0 : acc_r;
      out_err_r <= err_r;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign rect_sum     = out_sum_r;
  assign range_error  = out_err_r;

endmodule

`default_nettype wire

[sv/rectangle_sum_row_prefix.sv]
// Rectangle sum over a matrix held as per-row prefix sums.
// Request channel in_ch (valid/ready): req_type 0 loads the next element in
// row-major order, req_type 1 asks the sum of the inclusive rectangle
// top_row..bottom_row by left_col..right_col. Only queries return a result,
// on out_ch: rect_sum and range_error (set, with a zero sum, for coordinates
// outside the rows/columns in use or inverted).
// Configuration: cfg_we/cfg_idx/cfg_data write row_count (index 0) and
// col_count (index 1); write only while the block is idle.
// Loads are taken back to back. A query over n rows walks the rows at one
// prefix pair per cycle through the store's two read ports, then passes a
// drain and a finish state (error queries skip the walk and the drain); the
// result becomes valid as the block returns to idle for the next request.
// A request is taken while an earlier result still waits in the output
// register; a query that finishes while the receiver stalls holds until the
// register frees.
// Reset: rst_n (synchronous, low) clears the load position, running total
// and output valid, and sets both counts to 64. The prefix store is not
// cleared; query only entries already loaded.
// Depends on rsrp_pkg, rsrp_ifs, rsrp_ctrl and rsrp_dp.
`default_nettype none

module rectangle_sum_row_prefix #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rsrp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rsrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  rsrp_in_if.sink                               in_ch,
  rsrp_out_if.source                            out_ch
);

  rsrp_pkg::cmd_t cmd;
  rsrp_pkg::sts_t sts;
  logic           in_ready;

  // Sequencing
  rsrp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  assign in_ch.ready = in_ready;

  // Storage and arithmetic
  rsrp_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .element     (in_ch.element),
    .top_row     (in_ch.top_row),
    .left_col    (in_ch.left_col),
    .bottom_row  (in_ch.bottom_row),
    .right_col   (in_ch.right_col),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .rect_sum    (out_ch.rect_sum),
    .range_error (out_ch.range_error)
  );

endmodule

`default_nettype wire
